FILE: rtl/gcmb_pkg.sv
// Package for the mark bitmap: item types, widths, op and register codes, helpers.
`default_nettype none
package gcmb_pkg;

  localparam int ADDR_W     = 48;
  localparam int SHIFT_W    = 4;
  localparam int CELLS_W    = 17;
  localparam int OP_W       = 3;
  localparam int WIDX_W     = 10;
  localparam int COUNT_W    = 17;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int POP_W      = 7;
  localparam int CELL_W     = WIDX_W + BIT_W;
  localparam int OFF_W      = CELL_W + 15;
  localparam int NW_W       = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_MARK  = 3'd0;
  localparam logic [OP_W-1:0] OP_TEST  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
  localparam logic [OP_W-1:0] OP_ENUM  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_CELLS = 2'd2;

  localparam logic [SHIFT_W-1:0] CELL_SHIFT_RST = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [WIDX_W-1:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               in_range;
    logic [COUNT_W-1:0] marked_count;
    logic [ADDR_W-1:0]  marked_addr;
    logic               found;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SUB,
    ST_IDX,
    ST_RD,
    ST_MOD,
    ST_CLR,
    ST_CNT,
    ST_EN_RD,
    ST_EN_LOAD,
    ST_EN_SCAN,
    ST_EN_EMIT,
    ST_EMIT
  } state_t;

  // Population count of one byte
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

  // Population count of one word, as a sum of eight byte counts
  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, pop8(v[i*8 +: 8])};
    end
    return c;
  endfunction

  // Position of the lowest set bit (0 for an empty word)
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] one;
    logic [BIT_W-1:0]  b;
    one = v & (~v + 64'd1);
    b = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (one[j]) begin
        b = b | BIT_W'(j);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/gc_mark_bitmap.sv
// Mark bitmap top level: cell bitmap store, sequencer and item channels.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | input     | in_valid / in_stall  | in_item  (op, addr, word_index)
//  out_    | output    | out_valid / out_stall| out_item (hit ... last)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time, all through one single-port-write, registered-read word store.
// Mark/test: subtract, shift, read, modify, emit, in that order.
// Clear zeroes the words in use; count reads and popcounts each of them.
// Enumerate: one result per marked cell of the word; an empty word or a word out of range gives one result.
// Stalls on out_ hold the result back; a new item is taken only once the result is in the output register.
// After reset a clearing pass over all MAX_WORDS words runs with in_stall high.
`default_nettype none
module gc_mark_bitmap #(
  parameter int MAX_WORDS = 1024
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  gcmb_pkg::in_item_t           in_item,
  output logic                               out_valid,
  input  wire                                out_stall,
  output gcmb_pkg::out_item_t                out_item,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [gcmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [gcmb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [gcmb_pkg::NW_W-1:0] MAXW = gcmb_pkg::NW_W'(MAX_WORDS);

  // Configuration registers
  logic [gcmb_pkg::ADDR_W-1:0]  base_r;
  logic [gcmb_pkg::SHIFT_W-1:0] shift_r;
  logic [gcmb_pkg::NW_W-1:0]    nw_r;
  logic [gcmb_pkg::CELLS_W:0]   cells_sum;
  logic [gcmb_pkg::NW_W-1:0]    nw_raw;

  // Sequencer state
  gcmb_pkg::state_t state_r, state_nxt;
  logic [gcmb_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [gcmb_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [gcmb_pkg::WIDX_W-1:0]  widx_r, widx_nxt;
  logic [gcmb_pkg::ADDR_W-1:0]  diff_r, diff_nxt;
  logic                         below_r, below_nxt;
  logic [AW-1:0]                wa_r, wa_nxt;
  logic [gcmb_pkg::BIT_W-1:0]   bitpos_r, bitpos_nxt;
  logic [gcmb_pkg::NW_W-1:0]    ctr_r, ctr_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic                         pop_pend_r, pop_pend_nxt;
  logic [gcmb_pkg::POP_W-1:0]   pop_r, pop_nxt;
  logic [gcmb_pkg::COUNT_W-1:0] acc_r, acc_nxt;
  logic [gcmb_pkg::WORD_W-1:0]  vec_r, vec_nxt;
  logic [gcmb_pkg::OFF_W-1:0]   off_r, off_nxt;
  logic                         last_r, last_nxt;
  gcmb_pkg::out_item_t          res_r, res_nxt;
  gcmb_pkg::out_item_t          out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Store ports
  logic [gcmb_pkg::WORD_W-1:0]  mem_r [MAX_WORDS];
  logic [gcmb_pkg::WORD_W-1:0]  rdata_r;
  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [gcmb_pkg::WORD_W-1:0]  wr_data;

  // Datapath helpers
  logic                         out_free;
  logic [gcmb_pkg::ADDR_W:0]    sub_full;
  logic [gcmb_pkg::ADDR_W-1:0]  idx;
  logic [gcmb_pkg::ADDR_W-7:0]  widx_cell;
  logic                         idx_inr;
  logic [gcmb_pkg::NW_W-1:0]    widx_ext;
  logic [gcmb_pkg::COUNT_W:0]   acc_sum;
  logic                         bit_set;
  logic [gcmb_pkg::CELL_W-1:0]  cell_no;
  gcmb_pkg::out_item_t          res_zero;

  assign in_stall  = (state_r != gcmb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  // Words in use from a new cell count: ceiling over 64, capped at the store depth
  assign cells_sum = {1'b0, cfg_data[gcmb_pkg::CELLS_W-1:0]} + 18'd63;
  assign nw_raw    = gcmb_pkg::NW_W'(cells_sum[gcmb_pkg::CELLS_W:6]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      shift_r <= gcmb_pkg::CELL_SHIFT_RST;
      nw_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcmb_pkg::REG_HEAP_BASE:  base_r  <= cfg_data;
        gcmb_pkg::REG_CELL_SHIFT: shift_r <= cfg_data[gcmb_pkg::SHIFT_W-1:0];
        gcmb_pkg::REG_HEAP_CELLS: nw_r    <= (nw_raw > MAXW) ? MAXW : nw_raw;
        default: ;
      endcase
    end
  end

  // Bitmap store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // Shared datapath terms
  assign out_free  = !out_valid_r || !out_stall;
  assign sub_full  = {1'b0, addr_r} - {1'b0, base_r};
  assign idx       = diff_r >> shift_r;
  assign widx_cell = idx[gcmb_pkg::ADDR_W-1:6];
  assign idx_inr   = !below_r && (widx_cell[gcmb_pkg::ADDR_W-7:gcmb_pkg::NW_W] == '0)
                     && (widx_cell[gcmb_pkg::NW_W-1:0] < nw_r);
  assign widx_ext  = gcmb_pkg::NW_W'(widx_r);
  assign acc_sum   = {1'b0, acc_r} + gcmb_pkg::COUNT_W'(pop_r);
  assign bit_set   = rdata_r[bitpos_r];
  assign cell_no   = {widx_r, gcmb_pkg::low_bit(vec_r)};

  always_comb begin
    res_zero      = '0;
    res_zero.last = 1'b1;
  end

  // Next state, store control and results
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    widx_nxt      = widx_r;
    diff_nxt      = diff_r;
    below_nxt     = below_r;
    wa_nxt        = wa_r;
    bitpos_nxt    = bitpos_r;
    ctr_nxt       = ctr_r;
    rd_pend_nxt   = rd_pend_r;
    pop_pend_nxt  = pop_pend_r;
    pop_nxt       = pop_r;
    acc_nxt       = acc_r;
    vec_nxt       = vec_r;
    off_nxt       = off_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = ctr_r[AW-1:0];
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = wa_r;

    case (state_r)
      // Zero the whole store after reset
      gcmb_pkg::ST_INIT: begin
        if (ctr_r < MAXW) begin
          wr_en   = 1'b1;
          ctr_nxt = ctr_r + 1'b1;
        end else begin
          state_nxt = gcmb_pkg::ST_IDLE;
        end
      end

      // Take an item and dispatch on its op
      gcmb_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_item.op;
          addr_nxt     = in_item.addr;
          widx_nxt     = in_item.word_index;
          ctr_nxt      = '0;
          acc_nxt      = '0;
          rd_pend_nxt  = 1'b0;
          pop_pend_nxt = 1'b0;
          case (in_item.op)
            gcmb_pkg::OP_MARK,
            gcmb_pkg::OP_TEST:  state_nxt = gcmb_pkg::ST_SUB;
            gcmb_pkg::OP_CLEAR: state_nxt = gcmb_pkg::ST_CLR;
            gcmb_pkg::OP_COUNT: state_nxt = gcmb_pkg::ST_CNT;
            gcmb_pkg::OP_ENUM:  state_nxt = gcmb_pkg::ST_EN_RD;
            default: begin
              res_nxt   = res_zero;
              state_nxt = gcmb_pkg::ST_EMIT;
            end
          endcase
        end
      end

      // Offset from the heap base
      gcmb_pkg::ST_SUB: begin
        diff_nxt  = sub_full[gcmb_pkg::ADDR_W-1:0];
        below_nxt = sub_full[gcmb_pkg::ADDR_W];
        state_nxt = gcmb_pkg::ST_IDX;
      end

      // Cell index, word and bit; drop out-of-range addresses
      gcmb_pkg::ST_IDX: begin
        wa_nxt     = widx_cell[AW-1:0];
        bitpos_nxt = idx[gcmb_pkg::BIT_W-1:0];
        if (idx_inr) begin
          state_nxt = gcmb_pkg::ST_RD;
        end else begin
          res_nxt   = res_zero;
          state_nxt = gcmb_pkg::ST_EMIT;
        end
      end

      gcmb_pkg::ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = gcmb_pkg::ST_MOD;
      end

      // Test the bit, set it for mark
      gcmb_pkg::ST_MOD: begin
        res_nxt          = res_zero;
        res_nxt.in_range = 1'b1;
        if (op_r == gcmb_pkg::OP_MARK) begin
          res_nxt.hit = !bit_set;
          wr_en       = 1'b1;
          wr_addr     = wa_r;
          wr_data     = rdata_r | (64'd1 << bitpos_r);
        end else begin
          res_nxt.hit = bit_set;
        end
        state_nxt = gcmb_pkg::ST_EMIT;
      end

      // Zero the words in use
      gcmb_pkg::ST_CLR: begin
        if (ctr_r < nw_r) begin
          wr_en   = 1'b1;
          ctr_nxt = ctr_r + 1'b1;
        end else begin
          res_nxt   = res_zero;
          state_nxt = gcmb_pkg::ST_EMIT;
        end
      end

      // Read, popcount and accumulate, one word a cycle
      gcmb_pkg::ST_CNT: begin
        if (pop_pend_r) begin
          acc_nxt = acc_sum[gcmb_pkg::COUNT_W] ? gcmb_pkg::COUNT_MAX
                                               : acc_sum[gcmb_pkg::COUNT_W-1:0];
        end
        pop_pend_nxt = rd_pend_r;
        pop_nxt      = gcmb_pkg::pop64(rdata_r);
        if (ctr_r < nw_r) begin
          rd_en       = 1'b1;
          rd_addr     = ctr_r[AW-1:0];
          ctr_nxt     = ctr_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r && !pop_pend_r) begin
            res_nxt              = res_zero;
            res_nxt.marked_count = acc_r;
            state_nxt            = gcmb_pkg::ST_EMIT;
          end
        end
      end

      // Fetch the word to enumerate
      gcmb_pkg::ST_EN_RD: begin
        if (widx_ext >= nw_r) begin
          res_nxt   = res_zero;
          state_nxt = gcmb_pkg::ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = widx_ext[AW-1:0];
          state_nxt = gcmb_pkg::ST_EN_LOAD;
        end
      end

      gcmb_pkg::ST_EN_LOAD: begin
        vec_nxt = rdata_r;
        if (rdata_r == '0) begin
          res_nxt          = res_zero;
          res_nxt.in_range = 1'b1;
          state_nxt        = gcmb_pkg::ST_EMIT;
        end else begin
          state_nxt = gcmb_pkg::ST_EN_SCAN;
        end
      end

      // Pick the lowest marked cell and scale it to a byte offset
      gcmb_pkg::ST_EN_SCAN: begin
        off_nxt   = gcmb_pkg::OFF_W'(cell_no) << shift_r;
        vec_nxt   = vec_r & (vec_r - 64'd1);
        last_nxt  = ((vec_r & (vec_r - 64'd1)) == '0);
        state_nxt = gcmb_pkg::ST_EN_EMIT;
      end

      // Emit one cell address
      gcmb_pkg::ST_EN_EMIT: begin
        if (out_free) begin
          out_nxt             = '0;
          out_nxt.in_range    = 1'b1;
          out_nxt.marked_addr = base_r + gcmb_pkg::ADDR_W'(off_r);
          out_nxt.found       = 1'b1;
          out_nxt.last        = last_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = last_r ? gcmb_pkg::ST_IDLE : gcmb_pkg::ST_EN_SCAN;
        end
      end

      // Hand the single result to the output register
      gcmb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = gcmb_pkg::ST_IDLE;
        end
      end

      default: state_nxt = gcmb_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcmb_pkg::ST_INIT;
      ctr_r       <= '0;
      rd_pend_r   <= 1'b0;
      pop_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      pop_pend_r  <= pop_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    widx_r   <= widx_nxt;
    diff_r   <= diff_nxt;
    below_r  <= below_nxt;
    wa_r     <= wa_nxt;
    bitpos_r <= bitpos_nxt;
    pop_r    <= pop_nxt;
    acc_r    <= acc_nxt;
    vec_r    <= vec_nxt;
    off_r    <= off_nxt;
    last_r   <= last_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire
